/* design/chunk_offset_table_resolver_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the chunk offset table resolver
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef CHUNK_OFFSET_TABLE_RESOLVER_TOP_DEFINES_SVH
`define CHUNK_OFFSET_TABLE_RESOLVER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that prop holds at every clock edge outside reset.
`define COTR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that expr never becomes true outside reset.
`define COTR_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  `COTR_ASSERT(lbl, clk, rst, !(expr), msg)
`else
`define COTR_ASSERT(lbl, clk, rst, prop, msg)
`define COTR_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

/* design/cotr_pkg.sv */
// ----------------------------------------------------------------------------
// Chunk offset table resolver package
// Sizes, operation codes and status codes shared by the design files.
// ----------------------------------------------------------------------------
package cotr_pkg;

  localparam int MAX_CHUNKS  = 1024;
  localparam int CNT_W       = $clog2(MAX_CHUNKS + 1);
  localparam int ADDR_W      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int TOTAL_W     = 31;
  localparam int INDEX_W     = 32;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int CHUNK_NUM_W = 11;

  localparam logic [TOTAL_W-1:0] INT_MAX = {TOTAL_W{1'b1}};

  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND  = 2'd1;
  localparam logic [OP_W-1:0] OP_RESOLVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVER      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_AVAIL = 2'd3;

  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [ADDR_W-1:0]  addr_t;

endpackage

/* design/cotr_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one operation of the resolver.
// ----------------------------------------------------------------------------
interface cotr_req_if;
  logic                                valid;
  logic                                ready;
  logic [cotr_pkg::OP_W-1:0]           op;
  logic [cotr_pkg::TOTAL_W-1:0]        chunk_length;
  logic signed [cotr_pkg::INDEX_W-1:0] element_index;

  modport source (output valid, output op, output chunk_length, output element_index,
                  input ready);
  modport sink   (input valid, input op, input chunk_length, input element_index,
                  output ready);
endinterface

/* design/cotr_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result of the resolver.
// ----------------------------------------------------------------------------
interface cotr_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [cotr_pkg::STATUS_W-1:0]    status;
  logic [cotr_pkg::CHUNK_NUM_W-1:0] chunk_number;
  logic [cotr_pkg::TOTAL_W-1:0]     total_length;

  modport source (output valid, output status, output chunk_number, output total_length,
                  input ready);
  modport sink   (input valid, input status, input chunk_number, input total_length,
                  output ready);
endinterface

/* design/cotr_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cotr_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/chunk_offset_table_resolver_top.sv */
// ----------------------------------------------------------------------------
// Chunk offset table resolver
// Cumulative chunk offset table with append, clear and binary-search resolve.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per transaction: clear (empty the table),
//   append (add chunk_length to the running total and store the new offset)
//   or resolve (map element_index to the last table position whose offset
//   does not exceed it). rsp returns exactly one transaction per request
//   with status, chunk_number and the running total after the operation.
//   Clear and append move from S_IDLE to S_RESP and from there into the
//   output register, which raises rsp.valid. A resolve passes through
//   S_SEARCH and S_CMP once per halving of the search range; the loop is
//   one registered RAM read followed by one compare per step. An index that
//   is negative or above the total goes straight to S_RESP without a search.
//   Flow control: req.ready is high only while the sequencer is idle; one
//   request is in work at a time, and the next is taken only after the
//   previous result has left the sequencer for the output register. The
//   result register decouples rsp: a new request is accepted while the
//   previous result waits, and the sequencer holds its result until the
//   register frees up. Reset (rst, synchronous) empties the table and
//   zeroes the total; the offset memory needs no clearing since only
//   written entries are read.
// ----------------------------------------------------------------------------
`include "chunk_offset_table_resolver_top_defines.svh"

module chunk_offset_table_resolver_top (
  input logic      clk,
  input logic      rst,
  cotr_req_if.sink   req,
  cotr_rsp_if.source rsp
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_CMP    = 2'd2;
  localparam logic [1:0] S_RESP   = 2'd3;

  logic [1:0]                          state;
  cotr_pkg::count_t                    count;
  cotr_pkg::total_t                    total;

  // search registers
  cotr_pkg::count_t                    lo;
  cotr_pkg::count_t                    hi;
  cotr_pkg::count_t                    mid_q;
  cotr_pkg::total_t                    idx;

  // pending result
  logic [cotr_pkg::STATUS_W-1:0]       res_status;
  cotr_pkg::count_t                    res_number;

  // output register
  logic                                out_valid;
  logic [cotr_pkg::STATUS_W-1:0]       out_status;
  logic [cotr_pkg::CHUNK_NUM_W-1:0]    out_number;
  cotr_pkg::total_t                    out_total;

  logic                                req_fire;
  logic [cotr_pkg::TOTAL_W:0]          sum;
  logic                                full;
  logic                                ram_we;
  cotr_pkg::addr_t                     ram_raddr;
  cotr_pkg::total_t                    ram_rdata;
  logic [cotr_pkg::CNT_W:0]            mid_sum;
  cotr_pkg::count_t                    mid;
  logic                                range_open;
  logic                                out_free;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;

  // Shared adder and compare of the sequencer
  assign sum        = {1'b0, total} + {1'b0, req.chunk_length};
  assign full       = (count >= cotr_pkg::count_t'(cotr_pkg::MAX_CHUNKS));
  assign mid_sum    = {1'b0, lo} + {1'b0, hi};
  assign mid        = mid_sum[cotr_pkg::CNT_W:1];
  assign range_open = (({1'b0, lo} + 1'b1) < {1'b0, hi});
  assign out_free   = !out_valid || rsp.ready;

  // Store the new offset only for an append that fits
  assign ram_we    = req_fire && (req.op == cotr_pkg::OP_APPEND) && !full &&
                     !sum[cotr_pkg::TOTAL_W];
  // Position p lives at address p-1; mid is at least 1 whenever a read is issued
  assign ram_raddr = cotr_pkg::addr_t'(mid - 1'b1);

  cotr_ram #(
    .WIDTH (cotr_pkg::TOTAL_W),
    .DEPTH (cotr_pkg::MAX_CHUNKS)
  ) u_offsets (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cotr_pkg::addr_t'(count)),
    .wdata (sum[cotr_pkg::TOTAL_W-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the output once the receiver takes it, unless a new result
      // moves in at the same edge
      if (out_valid && rsp.ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            case (req.op)
              cotr_pkg::OP_CLEAR: begin
                count      <= '0;
                total      <= '0;
                res_status <= cotr_pkg::ST_OK;
                res_number <= '0;
                state      <= S_RESP;
              end
              cotr_pkg::OP_APPEND: begin
                state <= S_RESP;
                if (full) begin
                  res_status <= cotr_pkg::ST_FULL;
                  res_number <= count;
                end else if (sum[cotr_pkg::TOTAL_W]) begin
                  res_status <= cotr_pkg::ST_OVER;
                  res_number <= count;
                end else begin
                  count      <= count + 1'b1;
                  total      <= sum[cotr_pkg::TOTAL_W-1:0];
                  res_status <= cotr_pkg::ST_OK;
                  res_number <= count + 1'b1;
                end
              end
              cotr_pkg::OP_RESOLVE: begin
                if (req.element_index[cotr_pkg::INDEX_W-1] ||
                    (req.element_index[cotr_pkg::TOTAL_W-1:0] > total)) begin
                  res_status <= cotr_pkg::ST_NOT_AVAIL;
                  res_number <= '0;
                  state      <= S_RESP;
                end else begin
                  // Search positions 0..count, hi is exclusive
                  idx        <= req.element_index[cotr_pkg::TOTAL_W-1:0];
                  lo         <= '0;
                  hi         <= count + 1'b1;
                  res_status <= cotr_pkg::ST_OK;
                  state      <= S_SEARCH;
                end
              end
              default: begin
                // unused op code: report current state unchanged
                res_status <= cotr_pkg::ST_OK;
                res_number <= count;
                state      <= S_RESP;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (range_open) begin
            mid_q <= mid;
            state <= S_CMP;
          end else begin
            res_number <= lo;
            state      <= S_RESP;
          end
        end
        S_CMP: begin
          if (ram_rdata <= idx) begin
            lo <= mid_q;
          end else begin
            hi <= mid_q;
          end
          state <= S_SEARCH;
        end
        S_RESP: begin
          // Hold the result until the output register frees up
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_number <= cotr_pkg::CHUNK_NUM_W'(res_number);
            out_total  <= total;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.chunk_number = out_number;
  assign rsp.total_length = out_total;

  `COTR_ASSERT_NEVER(a_count_bound, clk, rst, count > cotr_pkg::count_t'(cotr_pkg::MAX_CHUNKS), "chunk count above table size")
  `COTR_ASSERT(a_search_order, clk, rst, (state == S_SEARCH || state == S_CMP) |-> (lo < hi), "search range empty")
  `COTR_ASSERT(a_cmp_after_read, clk, rst, (state == S_CMP) |-> ($past(state) == S_SEARCH), "compare without read")
  `COTR_ASSERT_NEVER(a_result_bound, clk, rst, (state == S_RESP) && (res_number > count), "result beyond chunk count")

endmodule
